/* rtl/nipd_pkg.sv */
// Package: widths, timing nominals, register indexes and window helpers for the NEC IR decoder.
`timescale 1ns / 1ps

package nipd_pkg;

  localparam int FIELD_BITS    = 16;
  localparam int DURATION_BITS = 16;
  localparam int WORD_BITS     = 2 * FIELD_BITS;
  localparam int COUNT_BITS    = $clog2(WORD_BITS + 1);
  localparam int TOL_BITS      = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // duration * 100 + 99 must fit
  localparam int PROD_BITS = DURATION_BITS + 7;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ADDRESS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMMAND   = 2'd2;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 7'd25;

  localparam logic [PROD_BITS-1:0] PCT_SCALE = PROD_BITS'(100);

  localparam logic [PROD_BITS-1:0] HDR_MARK   = PROD_BITS'(9000);
  localparam logic [PROD_BITS-1:0] HDR_SPACE  = PROD_BITS'(4500);
  localparam logic [PROD_BITS-1:0] BIT_MARK   = PROD_BITS'(560);
  localparam logic [PROD_BITS-1:0] ONE_SPACE  = PROD_BITS'(1690);

  // Window held as percent-scaled products: d passes when
  // lo <= 100*d + 99 and hi >= 100*d (same as the truncated bounds).
  typedef struct packed {
    logic [PROD_BITS-1:0] lo;
    logic [PROD_BITS-1:0] hi;
  } bounds_t;

  function automatic bounds_t win_bounds(input logic [TOL_BITS-1:0] tol,
                                         input logic [PROD_BITS-1:0] nom);
    bounds_t b;
    logic [PROD_BITS-1:0] tol_w;
    tol_w = PROD_BITS'(tol);
    if (tol_w >= PCT_SCALE) begin
      b.lo = '0;
    end else begin
      b.lo = PROD_BITS'((PCT_SCALE - tol_w) * nom);
    end
    b.hi = PROD_BITS'((PCT_SCALE + tol_w) * nom);
    return b;
  endfunction

  function automatic logic in_window(input logic [PROD_BITS-1:0] scaled,
                                     input bounds_t b);
    logic [PROD_BITS-1:0] top;
    top = scaled + PROD_BITS'(99);
    return (b.lo <= top) && (b.hi >= scaled);
  endfunction

endpackage

/* rtl/nipd_if.sv */
// Interfaces: pair input channel, result channel and configuration write channel.
`timescale 1ns / 1ps

interface nipd_item_if;
  logic                               valid;
  logic                               ready;
  logic [nipd_pkg::DURATION_BITS-1:0] mark_us;
  logic [nipd_pkg::DURATION_BITS-1:0] space_us;
  logic                               frame_start;

  modport source (output valid, mark_us, space_us, frame_start, input ready);
  modport sink   (input valid, mark_us, space_us, frame_start, output ready);
endinterface

interface nipd_result_if;
  logic                            valid;
  logic                            ready;
  logic                            frame_ok;
  logic [nipd_pkg::FIELD_BITS-1:0] address;
  logic [nipd_pkg::FIELD_BITS-1:0] command;
  logic                            matched;

  modport source (output valid, frame_ok, address, command, matched, input ready);
  modport sink   (input valid, frame_ok, address, command, matched, output ready);
endinterface

interface nipd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nipd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [nipd_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/nec_ir_pulse_decoder_core.sv */
// NEC infrared pulse-distance frame decoder, top level.
`timescale 1ns / 1ps

// Decodes NEC IR frames from measured mark/space pairs, one pair per beat on
// item_i. A beat with frame_start set must be the 9000/4500 us header; then
// 32 data pairs (560 us mark, 1690 us space = one, 560 us space = zero), MSB
// first, give 16 address and 16 command bits. After the 32nd bit one result
// beat is sent with frame_ok=1 and matched set when address and command equal
// the configured pair. The first bad pair gives one result with frame_ok=0
// and the bits gathered so far in place; pairs are then ignored until the
// next frame_start. A bad header gives frame_ok=0 with zero fields. Each
// duration passes within +/- tolerance_percent of nominal. Throughput is one
// pair per clock: a pair is registered on entry, then checked and shifted
// once the output register that holds any result can take it, so a beat is
// taken every cycle while the result side keeps up. Beats pass the input
// and result registers in turn. Window bounds are recomputed on a tolerance
// write, so no pair should be in flight then; writes are always accepted.
module nec_ir_pulse_decoder_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  nipd_item_if.sink        item_i,
  nipd_result_if.source    res_o,
  nipd_cfg_if.sink         cfg_i
);

  localparam int W  = nipd_pkg::WORD_BITS;
  localparam int FB = nipd_pkg::FIELD_BITS;
  localparam int CB = nipd_pkg::COUNT_BITS;
  localparam int PB = nipd_pkg::PROD_BITS;
  localparam int DB = nipd_pkg::DURATION_BITS;

  // ---------------------------------------------------------------------
  // Configuration: tolerance becomes precomputed window products
  // ---------------------------------------------------------------------
  nipd_pkg::bounds_t hdr_mark_q, hdr_space_q, bit_mark_q, one_space_q;
  logic [FB-1:0]     match_addr_q, match_cmd_q;
  logic              cfg_we;
  logic [nipd_pkg::TOL_BITS-1:0] cfg_tol;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign cfg_tol     = cfg_i.data[nipd_pkg::TOL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= nipd_pkg::win_bounds(nipd_pkg::TOL_RESET, nipd_pkg::HDR_MARK);
      hdr_space_q  <= nipd_pkg::win_bounds(nipd_pkg::TOL_RESET, nipd_pkg::HDR_SPACE);
      bit_mark_q   <= nipd_pkg::win_bounds(nipd_pkg::TOL_RESET, nipd_pkg::BIT_MARK);
      one_space_q  <= nipd_pkg::win_bounds(nipd_pkg::TOL_RESET, nipd_pkg::ONE_SPACE);
      match_addr_q <= '0;
      match_cmd_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_i.index)
        nipd_pkg::CFG_TOLERANCE: begin
          hdr_mark_q  <= nipd_pkg::win_bounds(cfg_tol, nipd_pkg::HDR_MARK);
          hdr_space_q <= nipd_pkg::win_bounds(cfg_tol, nipd_pkg::HDR_SPACE);
          bit_mark_q  <= nipd_pkg::win_bounds(cfg_tol, nipd_pkg::BIT_MARK);
          one_space_q <= nipd_pkg::win_bounds(cfg_tol, nipd_pkg::ONE_SPACE);
        end
        nipd_pkg::CFG_ADDRESS: begin
          match_addr_q <= FB'(cfg_i.data);
        end
        nipd_pkg::CFG_COMMAND: begin
          match_cmd_q <= FB'(cfg_i.data);
        end
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic          s1_valid_q;
  logic [DB-1:0] s1_mark_q, s1_space_q;
  logic          s1_start_q;
  logic          res_valid_q;
  logic          proc;       // s1 beat is processed this cycle
  logic          in_fire;

  assign proc         = s1_valid_q && (!res_valid_q || res_o.ready);
  assign item_i.ready = !s1_valid_q || proc;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (proc) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mark_q  <= item_i.mark_us;
      s1_space_q <= item_i.space_us;
      s1_start_q <= item_i.frame_start;
    end
  end

  // ---------------------------------------------------------------------
  // Pattern match: durations scaled by 100 against the window products
  // ---------------------------------------------------------------------
  logic [PB-1:0] mark_sc, space_sc;
  logic          hdr_fit, one_fit, zero_fit;

  assign mark_sc  = PB'(s1_mark_q) * nipd_pkg::PCT_SCALE;
  assign space_sc = PB'(s1_space_q) * nipd_pkg::PCT_SCALE;

  assign hdr_fit  = nipd_pkg::in_window(mark_sc, hdr_mark_q) &&
                    nipd_pkg::in_window(space_sc, hdr_space_q);
  // zero space shares the 560 us nominal with the bit mark
  assign one_fit  = nipd_pkg::in_window(mark_sc, bit_mark_q) &&
                    nipd_pkg::in_window(space_sc, one_space_q);
  assign zero_fit = nipd_pkg::in_window(mark_sc, bit_mark_q) &&
                    nipd_pkg::in_window(space_sc, bit_mark_q);

  // ---------------------------------------------------------------------
  // Frame state and result assembly
  // ---------------------------------------------------------------------
  logic          active_q, active_d;
  logic [CB-1:0] count_q, count_d;
  logic [W-1:0]  shift_q, shift_d;
  logic [W-1:0]  aligned;    // partial bits moved to their final place
  logic [W-1:0]  word;
  logic          emit, ok;

  assign aligned = shift_q << (CB'(W) - count_q);

  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    shift_d  = shift_q;
    emit     = 1'b0;
    ok       = 1'b0;
    word     = aligned;
    if (s1_start_q) begin
      count_d = '0;
      shift_d = '0;
      word    = '0;
      if (hdr_fit) begin
        active_d = 1'b1;
      end else begin
        active_d = 1'b0;
        emit     = 1'b1;
      end
    end else if (active_q) begin
      if (one_fit || zero_fit) begin
        shift_d = {shift_q[W-2:0], one_fit};
        count_d = count_q + CB'(1);
        if (count_d == CB'(W)) begin
          active_d = 1'b0;
          emit     = 1'b1;
          ok       = 1'b1;
          word     = shift_d;
        end
      end else begin
        active_d = 1'b0;
        emit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
      shift_q  <= '0;
    end else if (proc) begin
      active_q <= active_d;
      count_q  <= count_d;
      shift_q  <= shift_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic          res_ok_q, res_match_q;
  logic [FB-1:0] res_addr_q, res_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc) begin
      res_valid_q <= emit;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      res_ok_q    <= ok;
      res_addr_q  <= word[W-1:FB];
      res_cmd_q   <= word[FB-1:0];
      res_match_q <= ok && (word[W-1:FB] == match_addr_q) &&
                     (word[FB-1:0] == match_cmd_q);
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.frame_ok = res_ok_q;
  assign res_o.address  = res_addr_q;
  assign res_o.command  = res_cmd_q;
  assign res_o.matched  = res_match_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CB'(W))
    else $error("bit count beyond frame length");

  a_match_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (!res_match_q || res_ok_q))
    else $error("match flagged on an abandoned frame");

  a_stall_holds_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && res_valid_q && !res_o.ready) |=> s1_valid_q && $stable(count_q))
    else $error("pending pair lost or state moved while result stalled");

  a_full_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !s1_start_q && active_q && (one_fit || zero_fit) &&
     count_q == CB'(W - 1)) |=> res_valid_q && res_ok_q)
    else $error("last data bit did not produce a good result");

endmodule
